@@ design/pgbs_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pgbs_pkg
// Shared types, constants and helpers for the particle gravity/bounce step.
// ============================================================================
package pgbs_pkg;

    // Status codes at or below this value are active particles.
    localparam logic [7:0]  STATUS_LIMIT = 8'h46;
    // Right edge of the play field, 316.0 in 16.16.
    localparam logic [31:0] X_MAX        = 32'h013c_0000;
    // One half in 16.16, used for rounding to a pixel.
    localparam logic [31:0] ROUND_HALF   = 32'h0000_8000;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICKS   = 1'b0,
        CFG_GRAVITY = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [7:0]  status;
        logic        [31:0] row_word0;
        logic        [31:0] row_word1;
        logic        [31:0] row_word2;
        logic        [31:0] row_word3;
    } t_item;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_vx;
        logic signed [31:0] new_vy;
        logic        [7:0]  new_status;
        logic               draw;
        logic        [15:0] pixel_address;
        logic               below_bottom;
        logic        [31:0] write_word0;
        logic        [31:0] write_word1;
        logic        [31:0] write_word2;
        logic        [31:0] write_word3;
    } t_result;

    // Record after the ticks and the horizontal clamp.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] vx;
        logic [31:0] vy;
    } t_motion;

    // 16.16 to integer pixel: add one half, keep the upper 16 bits.
    function automatic logic [15:0] round_to_pixel(logic [31:0] v);
        logic [31:0] sum;
        sum = v + ROUND_HALF;
        return sum[31:16];
    endfunction

endpackage

@@ design/pgbs_kinematics.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pgbs_kinematics
// Closed-form Euler update over k ticks and horizontal clamp with bounce.
// ============================================================================
module pgbs_kinematics (
    input  pgbs_pkg::t_item   i_item,
    input  logic [7:0]        i_ticks,
    input  logic [31:0]       i_gravity,
    input  logic [14:0]       i_tri,
    output pgbs_pkg::t_motion o_motion
);

    logic [31:0] k_ext;
    logic [31:0] tri_ext;
    logic [31:0] k_vx;
    logic [31:0] k_vy;
    logic [31:0] k_g;
    logic [31:0] g_tri;
    logic [31:0] x_raw;
    logic [31:0] neg_vx;

    assign k_ext   = {24'b0, i_ticks};
    assign tri_ext = {17'b0, i_tri};

    // Four narrow multipliers in parallel, low 32 bits kept (wrap).
    assign k_vx  = k_ext * i_item.vel_x;
    assign k_vy  = k_ext * i_item.vel_y;
    assign k_g   = k_ext * i_gravity;
    assign g_tri = tri_ext * i_gravity;

    assign x_raw  = i_item.pos_x + k_vx;
    assign neg_vx = 32'd0 - i_item.vel_x;

    always_comb begin
        o_motion.y  = i_item.pos_y + k_vy + g_tri;
        o_motion.vy = i_item.vel_y + k_g;
        // Left edge wins; a clamped x of 0 can never hit the right edge.
        priority if ($signed(x_raw) <= 32'sd0) begin
            o_motion.x  = 32'd0;
            o_motion.vx = neg_vx;
        end else if ($signed(x_raw) >= $signed(pgbs_pkg::X_MAX)) begin
            o_motion.x  = pgbs_pkg::X_MAX;
            o_motion.vx = neg_vx;
        end else begin
            o_motion.x  = x_raw;
            o_motion.vx = i_item.vel_x;
        end
    end

endmodule

@@ design/pgbs_raster.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pgbs_raster
// Pixel rounding, row range check, framebuffer address and result assembly.
// ============================================================================
module pgbs_raster #(
    parameter int ROW_PITCH     = 320,
    parameter int LAST_DRAW_ROW = 196
) (
    input  pgbs_pkg::t_item   i_item,
    input  pgbs_pkg::t_motion i_motion,
    output pgbs_pkg::t_result o_result
);

    localparam int          ROW_W = $clog2(LAST_DRAW_ROW + 1);
    localparam logic [15:0] PITCH = 16'(ROW_PITCH);
    localparam logic [15:0] LAST  = 16'(LAST_DRAW_ROW);

    logic              active;
    logic [15:0]       row;
    logic [15:0]       col;
    logic [ROW_W-1:0]  row_n;
    logic [15:0]       pitch_row;
    logic              on_screen;
    logic              below;

    assign active = (i_item.status <= pgbs_pkg::STATUS_LIMIT);
    assign row    = pgbs_pkg::round_to_pixel(i_motion.y);
    assign col    = pgbs_pkg::round_to_pixel(i_motion.x);

    // Row is a signed 16-bit pixel; negative rows are neither drawn nor retired.
    assign on_screen = !row[15] && (row <= LAST);
    assign below     = !row[15] && (row > LAST);

    assign row_n     = row[ROW_W-1:0];
    assign pitch_row = 16'(PITCH * 16'(row_n));

    always_comb begin
        o_result = '0;
        if (active) begin
            o_result.new_x      = i_motion.x;
            o_result.new_y      = i_motion.y;
            o_result.new_vx     = i_motion.vx;
            o_result.new_vy     = i_motion.vy;
            o_result.new_status = below ? pgbs_pkg::STATUS_LIMIT : i_item.status;
            o_result.below_bottom = below;
            if (on_screen) begin
                o_result.draw          = 1'b1;
                o_result.pixel_address = col + pitch_row;
                o_result.write_word0   = i_item.row_word0;
                o_result.write_word1   = i_item.row_word1;
                o_result.write_word2   = i_item.row_word2;
                o_result.write_word3   = i_item.row_word3;
            end
        end else begin
            o_result.new_x      = i_item.pos_x;
            o_result.new_y      = i_item.pos_y;
            o_result.new_vx     = i_item.vel_x;
            o_result.new_vy     = i_item.vel_y;
            o_result.new_status = i_item.status;
        end
    end

endmodule

@@ design/particle_gravity_bounce_step_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// particle_gravity_bounce_step_core
// Advances one particle record per transaction: k gravity ticks in closed
// form, horizontal clamp and bounce, pixel rounding and sprite write setup.
// ============================================================================
// Usage:
//  - Input channel: drive a record on i_item with start high; it is taken at
//    any rising edge where start is high and busy is low. busy stays low, so
//    a new record may be offered every cycle.
//  - Result channel: o_done pulses for one cycle with o_result valid. The
//    receiver must take it then; there is no backpressure on this side.
//  - From the accepting edge, a record passes the input register, then the
//    result register, which raises o_done. Throughput is one
//    record per cycle, set by the single combinational pass of four 32x8 /
//    32x15 multiplies plus adds between the two registers.
//  - Config: i_cfg_we writes i_cfg_data to the register at i_cfg_index
//    (0 = ticks per call, 1 = gravity). Write only while no record is in
//    flight. The triangle number k(k+1)/2 is computed at write time.
//  - Reset (synchronous, active low) sets ticks to 1, gravity to 0 and drops
//    any record in flight; no result is produced for it.
// ============================================================================
module particle_gravity_bounce_step_core #(
    parameter int ROW_PITCH     = 320,
    parameter int LAST_DRAW_ROW = 196
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pgbs_pkg::t_item                      i_item,
    output logic                                 o_done,
    output pgbs_pkg::t_result                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [pgbs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pgbs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration state
    logic [7:0]  r_ticks;
    logic [31:0] r_gravity;
    logic [14:0] r_tri;
    logic [15:0] n_tri_prod;

    // Pipeline state
    logic              r_in_valid;
    pgbs_pkg::t_item   r_item;
    logic              r_done;
    pgbs_pkg::t_result r_result;

    pgbs_pkg::t_motion motion;
    pgbs_pkg::t_result n_result;

    // Never stalls: every offered record is accepted.
    assign busy = 1'b0;

    // k*(k+1) fits in 16 bits for k up to 255; halve it for the triangle number.
    assign n_tri_prod = {8'b0, i_cfg_data[7:0]} * ({8'b0, i_cfg_data[7:0]} + 16'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= 8'd1;
            r_gravity <= 32'd0;
            r_tri     <= 15'd1;
        end else if (i_cfg_we) begin
            unique case (pgbs_pkg::t_cfg_reg'(i_cfg_index))
                pgbs_pkg::CFG_TICKS: begin
                    r_ticks <= i_cfg_data[7:0];
                    r_tri   <= n_tri_prod[15:1];
                end
                pgbs_pkg::CFG_GRAVITY: begin
                    r_gravity <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: valid bit reset, payload free-running on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
    end

    pgbs_kinematics u_kinematics (
        .i_item    (r_item),
        .i_ticks   (r_ticks),
        .i_gravity (r_gravity),
        .i_tri     (r_tri),
        .o_motion  (motion)
    );

    pgbs_raster #(
        .ROW_PITCH     (ROW_PITCH),
        .LAST_DRAW_ROW (LAST_DRAW_ROW)
    ) u_raster (
        .i_item   (r_item),
        .i_motion (motion),
        .o_result (n_result)
    );

    // Result register: one-cycle strobe, no backpressure.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted transaction");

    a_draw_excludes_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.draw && o_result.below_bottom))
        else $error("particle both drawn and retired");

    a_below_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.below_bottom) |-> (o_result.new_status == pgbs_pkg::STATUS_LIMIT))
        else $error("retired particle has wrong status");

    a_no_draw_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.draw) |-> (o_result.pixel_address == 16'd0
            && o_result.write_word0 == 32'd0 && o_result.write_word3 == 32'd0))
        else $error("write payload present without draw");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.draw) |-> (!o_result.new_x[31]
            && o_result.new_x <= $signed(pgbs_pkg::X_MAX)))
        else $error("drawn particle outside horizontal clamp");

endmodule
